// ===== src/bdq_pkg.sv =====
// Package for the bounded deque with delete-by-value.
// Holds the sizes, operation and status codes, and the controller/datapath
// interface structs. No dependencies.
package bdq_pkg;

  // Storage depth and the cap on results of one print.
  localparam int DEPTH       = 32;
  localparam int MAX_RESULTS = 32;

  // Field widths.
  localparam int OP_W  = 4;
  localparam int VAL_W = 32;
  localparam int HM_W  = 7;
  localparam int ST_W  = 2;

  // Derived widths: entry index, occupancy count and remaining-results count.
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT = 4'd0,
    OP_ADD_BACK  = 4'd1,
    OP_DEL_FRONT = 4'd2,
    OP_DEL_BACK  = 4'd3,
    OP_CLEAR     = 4'd4,
    OP_DEL_VALUE = 4'd5,
    OP_PRINT_ALL = 4'd6,
    OP_PRINT_FST = 4'd7,
    OP_PRINT_LST = 4'd8
  } op_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_ENTRY = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // an item is taken this cycle
    logic delv_shift;  // close the gap left by a delete-by-value
    logic print_step;  // emit the next printed entry
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic prn_empty;   // the print being requested selects no entry
    logic prn_final;   // the current print step emits the final entry
  } dp_stat_t;

endpackage

// ===== src/bdq_ctrl.sv =====
// Controller state machine of the bounded deque.
// Depends on bdq_pkg; drives the command struct of bdq_datapath.
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] in_operation,
  input  dp_stat_t        stat,
  output logic            busy,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_DELV  = 3'b010,
    S_PRINT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && (state_r == S_IDLE);

  // Next state: delete-by-value goes through S_DELV, a non-empty print streams.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(in_operation))
            OP_DEL_VALUE: state_nxt = S_DELV;
            OP_PRINT_ALL,
            OP_PRINT_FST,
            OP_PRINT_LST: state_nxt = stat.prn_empty ? S_IDLE : S_PRINT;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_DELV:  state_nxt = S_IDLE;
      S_PRINT: state_nxt = stat.prn_final ? S_IDLE : S_PRINT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd.accept     = accept;
    cmd.delv_shift = (state_r == S_DELV);
    cmd.print_step = (state_r == S_PRINT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/bdq_datapath.sv =====
// Datapath of the bounded deque: row of shifting entry cells, occupancy,
// match vector, print counters and the result register. Depends on bdq_pkg.
module bdq_datapath
  import bdq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  input  logic [OP_W-1:0]         in_operation,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [HM_W-1:0]         in_how_many,
  output dp_stat_t                stat,
  output logic                    out_strobe,
  output logic [ST_W-1:0]         out_status,
  output logic signed [VAL_W-1:0] out_value_res,
  output logic                    out_last
);

  logic [VAL_W-1:0] cells_r [DEPTH];
  logic [VAL_W-1:0] cells_nxt [DEPTH];
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [DEPTH-1:0] match_r, match_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [RES_W-1:0] rem_r, rem_nxt;

  logic             strobe_r, strobe_nxt;
  status_t          status_r, status_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic             last_r, last_nxt;

  logic             full;
  logic [HM_W-1:0]  occ_ext;
  logic [HM_W-1:0]  sel_cnt;
  logic [HM_W-1:0]  prn_cnt;
  logic [HM_W-1:0]  prn_start;
  logic [DEPTH-1:0] gap_mask;

  assign full    = (occ_r == CNT_W'(DEPTH));
  assign occ_ext = HM_W'(occ_r);

  // Entries selected by a print request, capped at the result limit.
  always_comb begin
    case (op_t'(in_operation))
      OP_PRINT_ALL: sel_cnt = occ_ext;
      default:      sel_cnt = (in_how_many > occ_ext) ? occ_ext : in_how_many;
    endcase
    prn_cnt   = (sel_cnt > HM_W'(MAX_RESULTS)) ? HM_W'(MAX_RESULTS) : sel_cnt;
    prn_start = (op_t'(in_operation) == OP_PRINT_LST) ? (occ_ext - sel_cnt) : '0;
  end

  assign stat.prn_empty = (prn_cnt == '0);
  assign stat.prn_final = (rem_r == RES_W'(1));

  // Cells at or after the first match; a log-step prefix OR.
  always_comb begin
    gap_mask = match_r;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      gap_mask = gap_mask | (gap_mask << s);
    end
  end

  // Compare every valid cell against the value to delete.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_nxt[i] = (cells_r[i] == in_value) && (CNT_W'(i) < occ_r);
    end
  end

  // Mutations, print setup and result generation.
  always_comb begin
    cells_nxt  = cells_r;
    occ_nxt    = occ_r;
    idx_nxt    = idx_r;
    rem_nxt    = rem_r;
    strobe_nxt = 1'b0;
    status_nxt = ST_ENTRY;
    value_nxt  = '0;
    last_nxt   = 1'b1;

    if (cmd.accept) begin
      case (op_t'(in_operation))
        OP_ADD_FRONT: begin
          if (full) begin
            strobe_nxt = 1'b1;
            status_nxt = ST_FULL;
          end else begin
            for (int i = 1; i < DEPTH; i++) begin
              cells_nxt[i] = cells_r[i-1];
            end
            cells_nxt[0] = in_value;
            occ_nxt      = occ_r + 1'b1;
          end
        end
        OP_ADD_BACK: begin
          if (full) begin
            strobe_nxt = 1'b1;
            status_nxt = ST_FULL;
          end else begin
            cells_nxt[occ_r[IDX_W-1:0]] = in_value;
            occ_nxt = occ_r + 1'b1;
          end
        end
        OP_DEL_FRONT: begin
          if (occ_r != '0) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
              cells_nxt[i] = cells_r[i+1];
            end
            occ_nxt = occ_r - 1'b1;
          end
        end
        OP_DEL_BACK: begin
          if (occ_r != '0) begin
            occ_nxt = occ_r - 1'b1;
          end
        end
        OP_CLEAR: begin
          occ_nxt = '0;
        end
        OP_PRINT_ALL, OP_PRINT_FST, OP_PRINT_LST: begin
          if (prn_cnt == '0) begin
            strobe_nxt = 1'b1;
            status_nxt = ST_EMPTY;
          end else begin
            idx_nxt = prn_start[IDX_W-1:0];
            rem_nxt = RES_W'(prn_cnt);
          end
        end
        default: begin
          // Delete-by-value acts next cycle; unknown codes do nothing.
        end
      endcase
    end

    // In S_DELV of delete-by-value: later cells move up over the match.
    if (cmd.delv_shift && (match_r != '0)) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (gap_mask[i]) begin
          cells_nxt[i] = cells_r[i+1];
        end
      end
      occ_nxt = occ_r - 1'b1;
    end

    // One printed entry per cycle, front to back.
    if (cmd.print_step) begin
      strobe_nxt = 1'b1;
      status_nxt = ST_ENTRY;
      value_nxt  = cells_r[idx_r];
      last_nxt   = (rem_r == RES_W'(1));
      idx_nxt    = idx_r + 1'b1;
      rem_nxt    = rem_r - 1'b1;
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      occ_r    <= occ_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cells_r  <= cells_nxt;
    idx_r    <= idx_nxt;
    rem_r    <= rem_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
    last_r   <= last_nxt;
    if (cmd.accept) begin
      match_r <= match_nxt;
    end
  end

  assign out_strobe    = strobe_r;
  assign out_status    = status_r;
  assign out_value_res = value_r;
  assign out_last      = last_r;

endmodule

// ===== src/bounded_deque_with_value_delete_unit.sv =====
// Top level of the bounded deque with delete-by-value.
// Depends on bdq_pkg, bdq_ctrl and bdq_datapath.
//
// An item is taken when start is high and busy is low. Add, delete front,
// delete back and clear finish at the edge that takes them, so the next item
// can follow in the very next cycle. Delete-by-value first compares every
// cell, then shifts the later cells over the match. A print keeps busy high
// while its entries stream out, the cell row having a single read port that
// yields one entry per cycle. Every result is registered and appears on the
// out_ ports for one cycle, marked by out_strobe; the receiver cannot stall,
// so it must take each result as it comes. Printed entries arrive front to
// back in consecutive cycles with out_last on the final one; an empty print
// and a dropped add to a full deque give a single result with out_last set.
module bounded_deque_with_value_delete_unit
  import bdq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         in_operation,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [HM_W-1:0]         in_how_many,
  output logic                    out_strobe,
  output logic [ST_W-1:0]         out_status,
  output logic signed [VAL_W-1:0] out_value_res,
  output logic                    out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing of multi-cycle operations.
  bdq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .busy         (busy),
    .cmd          (cmd)
  );

  // Storage and result generation.
  bdq_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_operation  (in_operation),
    .in_value      (in_value),
    .in_how_many   (in_how_many),
    .stat          (stat),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_value_res (out_value_res),
    .out_last      (out_last)
  );

endmodule

// ===== src/bdq_checker.sv =====
// Port-level assertions for the bounded deque top level, and the bind that
// attaches them. Depends on bdq_pkg.
module bdq_checker
  import bdq_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic [OP_W-1:0]         in_operation,
  input logic                    out_strobe,
  input logic [ST_W-1:0]         out_status,
  input logic signed [VAL_W-1:0] out_value_res,
  input logic                    out_last
);

  // Flag results always close their run.
  a_flag_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_ENTRY) |-> out_last)
    else $error("flag result without last mark");

  // Flag results carry a zero value.
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_ENTRY) |-> (out_value_res == '0))
    else $error("flag result with nonzero value");

  // A print stream has no gaps before its final entry.
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("print stream broken before last entry");

  // While a print is still streaming the block takes no new item.
  a_busy_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy)
    else $error("not busy in the middle of a print");

  // Plain deletes and clear finish at once and give no result.
  a_del_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && ((in_operation == OP_DEL_FRONT) ||
      (in_operation == OP_DEL_BACK) || (in_operation == OP_CLEAR))
    |=> !out_strobe && !busy)
    else $error("delete or clear produced a result or stayed busy");

endmodule

bind bounded_deque_with_value_delete_unit bdq_checker u_bdq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_operation  (in_operation),
  .out_strobe    (out_strobe),
  .out_status    (out_status),
  .out_value_res (out_value_res),
  .out_last      (out_last)
);
